// ===== rtl/uhbc_pkg.sv =====
// Shared constants, codes and control types for the hash bucket collision counter.
package uhbc_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int SUM_W       = 20;
    localparam int CFG_W       = 16;
    localparam int BCNT_W      = 11;
    localparam int CNT_W       = 16;
    localparam int IDX_W       = $clog2(MAX_BUCKETS);
    localparam int V_W         = CFG_W + SUM_W + 1;
    localparam int DIV_W       = CFG_W;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULTIPLIER,
        CFG_OFFSET,
        CFG_PRIME,
        CFG_BUCKETS
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_R1_GO,
        ST_R1_WAIT,
        ST_R2_GO,
        ST_R2_WAIT,
        ST_RD,
        ST_UPD
    } ctrl_state_t;

    typedef struct packed {
        logic acc;
        logic clr_wr;
        logic mul;
        logic rem_start;
        logic rem_take;
        logic rem_pass2;
        logic mem_rd;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic p_zero;
        logic rem_done;
    } dp_status_t;

endpackage

// ===== rtl/uhbc_ctrl.sv =====
// Controller state machine: clearing pass, byte intake, hash sequencing and result hand-off.
module uhbc_ctrl
    import uhbc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last_byte,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:    if (s_valid && s_last_byte) state_next = ST_MUL;
            ST_MUL:     state_next = status.p_zero ? ST_R2_GO : ST_R1_GO;
            ST_R1_GO:   state_next = ST_R1_WAIT;
            ST_R1_WAIT: if (status.rem_done) state_next = ST_R2_GO;
            ST_R2_GO:   state_next = ST_R2_WAIT;
            ST_R2_WAIT: if (status.rem_done) state_next = ST_RD;
            ST_RD:      state_next = ST_UPD;
            ST_UPD:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:   cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.acc = s_valid;
            end
            ST_MUL:     cmd.mul = 1'b1;
            ST_R1_GO:   cmd.rem_start = 1'b1;
            ST_R1_WAIT: cmd.rem_take = status.rem_done;
            ST_R2_GO: begin
                cmd.rem_start = 1'b1;
                cmd.rem_pass2 = 1'b1;
            end
            ST_R2_WAIT: begin
                cmd.rem_take  = status.rem_done;
                cmd.rem_pass2 = 1'b1;
            end
            ST_RD:      cmd.mem_rd = 1'b1;
            ST_UPD:     cmd.update = out_free;
            default:    cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.update) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A new result may only be loaded when the output slot is empty or being emptied.
    a_update_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending one");

    a_valid_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_UPD)
        else $error("result valid raised outside the update step");

endmodule

// ===== rtl/uhbc_rem_div.sv =====
// Shared restoring remainder unit, one dividend bit per cycle.
module uhbc_rem_div
    import uhbc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [V_W-1:0]   dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int IT_W = $clog2(V_W);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(V_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IT_W-1:0]  cnt_reg, cnt_next;
    logic [V_W-1:0]   q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] r_step;

    assign trial  = {r_reg, q_reg[V_W-1]};
    assign diff   = trial - {1'b0, d_reg};
    assign r_step = (trial >= {1'b0, d_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            q_next   = {q_reg[V_W-2:0], 1'b0};
            r_next   = r_step;
            if (cnt_reg == LAST_IT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done      = done_reg;
    assign remainder = r_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

endmodule

// ===== rtl/uhbc_datapath.sv =====
// Datapath: configuration registers, key accumulator, hash arithmetic, bucket memory and result registers.
module uhbc_datapath
    import uhbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [7:0]           s_key_byte,
    input  logic                 s_last_byte,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic [IDX_W-1:0]     m_bucket_index,
    output logic [CNT_W-1:0]     m_bucket_collisions,
    output logic [CNT_W-1:0]     m_total_collisions
);

    logic [CFG_W-1:0]  mult_reg, mult_next;
    logic [CFG_W-1:0]  offs_reg, offs_next;
    logic [CFG_W-1:0]  prime_reg, prime_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [SUM_W-1:0]  key_sum_reg, key_sum_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;

    logic [SUM_W-1:0]  key_reg, key_next;
    logic [V_W-1:0]    v_reg, v_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rd_reg;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [CNT_W-1:0]  out_coll_reg, out_coll_next;

    logic [CNT_W-1:0]  mem [MAX_BUCKETS];

    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [BCNT_W-1:0] m_eff;
    logic [DIV_W-1:0]  divisor;
    logic              rem_done;
    logic [DIV_W-1:0]  rem;
    logic [CNT_W-1:0]  new_cnt;
    logic              cnt_full;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;

    assign sum_wide = {1'b0, key_sum_reg} + (SUM_W + 1)'(s_key_byte);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_comb begin
        if (bcnt_reg == '0) begin
            m_eff = BCNT_W'(1);
        end else if (bcnt_reg > BCNT_W'(MAX_BUCKETS)) begin
            m_eff = BCNT_W'(MAX_BUCKETS);
        end else begin
            m_eff = bcnt_reg;
        end
    end

    assign divisor = cmd.rem_pass2 ? DIV_W'(m_eff) : prime_reg;

    uhbc_rem_div u_rem_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (v_reg),
        .divisor   (divisor),
        .done      (rem_done),
        .remainder (rem)
    );

    assign status.clear_done = (clr_addr_reg == IDX_W'(MAX_BUCKETS - 1));
    assign status.p_zero     = (prime_reg == '0);
    assign status.rem_done   = rem_done;

    assign cnt_full = (rd_reg == {CNT_W{1'b1}});
    assign new_cnt  = cnt_full ? rd_reg : rd_reg + 1'b1;

    always_comb begin
        mult_next     = mult_reg;
        offs_next     = offs_reg;
        prime_next    = prime_reg;
        bcnt_next     = bcnt_reg;
        key_sum_next  = key_sum_reg;
        total_next    = total_reg;
        clr_addr_next = clr_addr_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MULTIPLIER: mult_next  = cfg_data;
                CFG_OFFSET:     offs_next  = cfg_data;
                CFG_PRIME:      prime_next = cfg_data;
                CFG_BUCKETS:    bcnt_next  = cfg_data[BCNT_W-1:0];
                default:        mult_next  = mult_reg;
            endcase
        end
        if (cmd.acc) begin
            key_sum_next = s_last_byte ? '0 : sum_sat;
        end
        if (cmd.clr_wr) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (cmd.update && !cnt_full && rd_reg != '0 && total_reg != {CNT_W{1'b1}}) begin
            total_next = total_reg + 1'b1;
        end
    end

    always_comb begin
        key_next      = key_reg;
        v_next        = v_reg;
        idx_next      = idx_reg;
        out_idx_next  = out_idx_reg;
        out_coll_next = out_coll_reg;
        if (cmd.acc && s_last_byte) begin
            key_next = sum_sat;
        end
        if (cmd.mul) begin
            v_next = V_W'(mult_reg) * V_W'(key_reg) + V_W'(offs_reg);
        end
        if (cmd.rem_take && !cmd.rem_pass2) begin
            v_next = V_W'(rem);
        end
        if (cmd.rem_take && cmd.rem_pass2) begin
            idx_next = rem[IDX_W-1:0];
        end
        if (cmd.update) begin
            out_idx_next  = idx_reg;
            out_coll_next = new_cnt - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg     <= CFG_W'(1);
            offs_reg     <= '0;
            prime_reg    <= CFG_W'(65521);
            bcnt_reg     <= BCNT_W'(MAX_BUCKETS);
            key_sum_reg  <= '0;
            total_reg    <= '0;
            clr_addr_reg <= '0;
        end else begin
            mult_reg     <= mult_next;
            offs_reg     <= offs_next;
            prime_reg    <= prime_next;
            bcnt_reg     <= bcnt_next;
            key_sum_reg  <= key_sum_next;
            total_reg    <= total_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        v_reg        <= v_next;
        idx_reg      <= idx_next;
        out_idx_reg  <= out_idx_next;
        out_coll_reg <= out_coll_next;
    end

    assign mem_we    = cmd.clr_wr || cmd.update;
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : new_cnt;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign m_bucket_index      = out_idx_reg;
    assign m_bucket_collisions = out_coll_reg;
    assign m_total_collisions  = total_reg;

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> total_reg >= $past(total_reg))
        else $error("collision total decreased");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> BCNT_W'(idx_reg) < m_eff)
        else $error("bucket index beyond the buckets in use");

endmodule

// ===== rtl/universal_hash_bucket_collision_counter_core.sv =====
// Top level of the universal hash bucket collision counter.
// A key byte that is not the last is added to the key sum; the next request is accepted at once.
// A last byte yields its result after the multiply step, two bit-serial remainder passes over the
// 37-bit value (only the second when the prime is zero) and the bucket memory read and update.
// While a result waits to be taken, key bytes are still accepted until the next last byte.
// After reset a clearing pass zeroes all 1024 bucket counters; no request is accepted during it.
module universal_hash_bucket_collision_counter_core
    import uhbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_key_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_bucket_index,
    output logic [CNT_W-1:0]     m_bucket_collisions,
    output logic [CNT_W-1:0]     m_total_collisions
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    uhbc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    uhbc_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_key_byte          (s_key_byte),
        .s_last_byte         (s_last_byte),
        .cmd                 (cmd),
        .status              (status),
        .m_bucket_index      (m_bucket_index),
        .m_bucket_collisions (m_bucket_collisions),
        .m_total_collisions  (m_total_collisions)
    );

endmodule
